// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the timer pool (tick_timer_pool).
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ===== src/ttp_pkg.sv =====
// Types and constants for the tick timer pool.
// No dependencies; used by tick_timer_pool.
package ttp_pkg;

    localparam int POOL_SIZE_DEF   = 16;
    localparam int NUM_CHAN        = 3;
    localparam int COUNT_W         = 32;
    localparam int SLOT_OUT_W      = 5;
    localparam int FIRE_W          = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [COUNT_W-1:0] MID_PERIOD_RST  = 32'd20;
    localparam logic [COUNT_W-1:0] SLOW_PERIOD_RST = 32'd100;
    localparam logic [FIRE_W-1:0]  CALLBACK_RST    = 3'd0;

    // Channel code that addresses nothing
    localparam logic [1:0] CHAN_INVALID = 2'd3;

    typedef enum logic [3:0] {
        KIND_TICK        = 4'd0,
        KIND_ALLOC       = 4'd1,
        KIND_POOL_STOP   = 4'd2,
        KIND_POOL_READ   = 4'd3,
        KIND_POOL_LESS   = 4'd4,
        KIND_POOL_MORE   = 4'd5,
        KIND_POOL_STATUS = 4'd6,
        KIND_CH_START    = 4'd7,
        KIND_CH_STOP     = 4'd8,
        KIND_CH_READ     = 4'd9,
        KIND_CH_LESS     = 4'd10,
        KIND_CH_MORE     = 4'd11,
        KIND_CH_STATUS   = 4'd12
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CALLBACK_MASK = 2'd0,
        CFG_MID_PERIOD    = 2'd1,
        CFG_SLOW_PERIOD   = 2'd2
    } cfg_reg_t;

endpackage

// ===== src/tick_timer_pool.sv =====
// Tick timer pool: POOL_SIZE elapsed-time counters plus three periodic channels.
// Depends on ttp_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per tick or
//   command: kind, slot_in, channel, limit_ms. Every input transaction gives
//   exactly one result transaction on the output channel (out_valid/out_ready):
//   slot_out, elapsed, flag, fire_mask; fields a command does not use read 0.
//   Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; index 0 callback_mask, 1 mid_period, 2 slow_period, others dropped.
//   Write it only while no command is in flight.
// Timing:
//   An item is held in the input register, is executed there and lands in the
//   result register, which drives out_valid. One item per cycle is sustained
//   while out_ready stays high; the single execute stage that reads and
//   updates all counters in place sets that rate.
// Stall and reset:
//   When out_ready is low the result holds, the input register fills and then
//   in_ready drops. Reset clears all counters, running and enable bits and
//   loads callback_mask 0, mid_period 20 and slow_period 100.
`include "assert_macros.svh"

module tick_timer_pool #(
    parameter int POOL_SIZE = ttp_pkg::POOL_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [3:0]                        kind,
    input  logic [3:0]                        slot_in,
    input  logic [1:0]                        channel,
    input  logic [ttp_pkg::COUNT_W-1:0]       limit_ms,
    // result output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ttp_pkg::SLOT_OUT_W-1:0]    slot_out,
    output logic [ttp_pkg::COUNT_W-1:0]       elapsed,
    output logic                              flag,
    output logic [ttp_pkg::FIRE_W-1:0]        fire_mask,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ttp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(POOL_SIZE + 1);
    localparam int CW    = ttp_pkg::COUNT_W;
    localparam int NCH   = ttp_pkg::NUM_CHAN;

    // configuration
    logic [ttp_pkg::FIRE_W-1:0] callback_mask_reg;
    logic [CW-1:0]              mid_period_reg;
    logic [CW-1:0]              slow_period_reg;

    // input register
    logic                       in_valid_reg;
    logic [3:0]                 kind_reg;
    logic [3:0]                 slot_in_reg;
    logic [1:0]                 channel_reg;
    logic [CW-1:0]              limit_reg;

    // state
    logic [CW-1:0]              pool_count_reg  [POOL_SIZE];
    logic [CW-1:0]              pool_count_next [POOL_SIZE];
    logic [POOL_SIZE-1:0]       pool_running_reg;
    logic [POOL_SIZE-1:0]       pool_running_next;
    logic [CW-1:0]              chan_count_reg  [NCH];
    logic [CW-1:0]              chan_count_next [NCH];
    logic [NCH-1:0]             chan_enabled_reg;
    logic [NCH-1:0]             chan_enabled_next;

    // result register
    logic                           out_valid_reg;
    logic [ttp_pkg::SLOT_OUT_W-1:0] slot_out_reg;
    logic [CW-1:0]                  elapsed_reg;
    logic                           flag_reg;
    logic [ttp_pkg::FIRE_W-1:0]     fire_mask_reg;

    // execute stage
    logic                           exec_fire;
    logic [POOL_SIZE-1:0]           slot_hit;
    logic [POOL_SIZE-1:0]           free_oh;
    logic                           any_free;
    logic [IDX_W-1:0]               free_idx;
    logic [IDX_W+ttp_pkg::SLOT_OUT_W-1:0] free_idx_ext;
    logic [CW-1:0]                  sel_count;
    logic                           sel_running;
    logic                           slot_ok;
    logic                           ch_ok;
    logic [CW-1:0]                  ch_count;
    logic                           ch_enabled;
    logic [CW-1:0]                  chan_inc;
    logic [CW-1:0]                  period;
    logic                           cmp_hit;
    logic [ttp_pkg::SLOT_OUT_W-1:0] res_slot;
    logic [CW-1:0]                  res_elapsed;
    logic                           res_flag;
    logic [ttp_pkg::FIRE_W-1:0]     res_fire;
    logic [POOL_SIZE-1:0]           idle_dirty;

    assign exec_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || exec_fire;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign slot_out  = slot_out_reg;
    assign elapsed   = elapsed_reg;
    assign flag      = flag_reg;
    assign fire_mask = fire_mask_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            callback_mask_reg <= ttp_pkg::CALLBACK_RST;
            mid_period_reg    <= ttp_pkg::MID_PERIOD_RST;
            slow_period_reg   <= ttp_pkg::SLOW_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ttp_pkg::cfg_reg_t'(cfg_index))
                ttp_pkg::CFG_CALLBACK_MASK: callback_mask_reg <= cfg_data[ttp_pkg::FIRE_W-1:0];
                ttp_pkg::CFG_MID_PERIOD:    mid_period_reg    <= cfg_data[CW-1:0];
                ttp_pkg::CFG_SLOW_PERIOD:   slow_period_reg   <= cfg_data[CW-1:0];
                default:                    ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg    <= kind;
            slot_in_reg <= slot_in;
            channel_reg <= channel;
            limit_reg   <= limit_ms;
        end
    end

    // slot decode, lowest free slot
    always_comb
    begin
        any_free = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            slot_hit[i] = (int'(slot_in_reg) == i);
            free_oh[i]  = !pool_running_reg[i] && !any_free;
            if (!pool_running_reg[i])
            begin
                any_free = 1'b1;
            end
        end
        free_idx = IDX_W'(POOL_SIZE);
        for (int i = POOL_SIZE - 1; i >= 0; i--)
        begin
            if (!pool_running_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        free_idx_ext = {{ttp_pkg::SLOT_OUT_W{1'b0}}, free_idx};
    end

    // addressed pool counter and channel
    always_comb
    begin
        sel_count   = '0;
        sel_running = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (slot_hit[i])
            begin
                sel_count   = sel_count | pool_count_reg[i];
                sel_running = sel_running | pool_running_reg[i];
            end
        end
        slot_ok    = |slot_hit;
        ch_ok      = (channel_reg != ttp_pkg::CHAN_INVALID);
        ch_count   = ch_ok ? chan_count_reg[channel_reg] : '0;
        ch_enabled = ch_ok ? chan_enabled_reg[channel_reg] : 1'b0;
    end

    // execute one item
    always_comb
    begin
        pool_count_next   = pool_count_reg;
        pool_running_next = pool_running_reg;
        chan_count_next   = chan_count_reg;
        chan_enabled_next = chan_enabled_reg;
        res_slot    = '0;
        res_elapsed = '0;
        res_flag    = 1'b0;
        res_fire    = '0;
        chan_inc    = '0;
        period      = '0;
        cmp_hit     = 1'b0;
        case (ttp_pkg::kind_t'(kind_reg))
            ttp_pkg::KIND_TICK:
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    chan_inc = chan_count_reg[c] + 32'd1;
                    period   = (c == 1) ? mid_period_reg : slow_period_reg;
                    if (chan_enabled_reg[c])
                    begin
                        chan_count_next[c] = chan_inc;
                        if (callback_mask_reg[c])
                        begin
                            if (c == 0)
                            begin
                                res_fire[c] = 1'b1;
                            end
                            else if (chan_inc > period)
                            begin
                                // restart, channel stays enabled
                                chan_count_next[c] = '0;
                                res_fire[c]        = 1'b1;
                            end
                        end
                    end
                end
                for (int i = 0; i < POOL_SIZE; i++)
                begin
                    if (pool_running_reg[i])
                    begin
                        pool_count_next[i] = pool_count_reg[i] + 32'd1;
                    end
                end
            end
            ttp_pkg::KIND_ALLOC:
            begin
                res_slot = free_idx_ext[ttp_pkg::SLOT_OUT_W-1:0];
                for (int i = 0; i < POOL_SIZE; i++)
                begin
                    if (free_oh[i])
                    begin
                        pool_running_next[i] = 1'b1;
                        pool_count_next[i]   = '0;
                    end
                end
            end
            ttp_pkg::KIND_POOL_STOP:
            begin
                for (int i = 0; i < POOL_SIZE; i++)
                begin
                    if (slot_hit[i])
                    begin
                        pool_running_next[i] = 1'b0;
                        pool_count_next[i]   = '0;
                    end
                end
            end
            ttp_pkg::KIND_POOL_READ:
            begin
                res_elapsed = sel_count;
            end
            ttp_pkg::KIND_POOL_LESS,
            ttp_pkg::KIND_POOL_MORE:
            begin
                cmp_hit = (kind_reg == ttp_pkg::KIND_POOL_LESS) ? (sel_count < limit_reg)
                                                                 : (sel_count > limit_reg);
                res_flag = slot_ok && cmp_hit;
                // a true answer stops the counter
                for (int i = 0; i < POOL_SIZE; i++)
                begin
                    if (slot_hit[i] && cmp_hit)
                    begin
                        pool_running_next[i] = 1'b0;
                        pool_count_next[i]   = '0;
                    end
                end
            end
            ttp_pkg::KIND_POOL_STATUS:
            begin
                res_flag = sel_running;
            end
            ttp_pkg::KIND_CH_START:
            begin
                if (ch_ok)
                begin
                    chan_count_next[channel_reg]   = '0;
                    chan_enabled_next[channel_reg] = 1'b1;
                end
            end
            ttp_pkg::KIND_CH_STOP:
            begin
                if (ch_ok)
                begin
                    chan_count_next[channel_reg]   = '0;
                    chan_enabled_next[channel_reg] = 1'b0;
                end
            end
            ttp_pkg::KIND_CH_READ:
            begin
                res_elapsed = ch_count;
            end
            ttp_pkg::KIND_CH_LESS:
            begin
                res_flag = ch_ok && (ch_count < limit_reg);
            end
            ttp_pkg::KIND_CH_MORE:
            begin
                res_flag = ch_ok && (ch_count > limit_reg);
            end
            ttp_pkg::KIND_CH_STATUS:
            begin
                res_flag = ch_enabled;
            end
            default:
            begin
            end
        endcase
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                pool_count_reg[i] <= '0;
            end
            for (int c = 0; c < NCH; c++)
            begin
                chan_count_reg[c] <= '0;
            end
            pool_running_reg <= '0;
            chan_enabled_reg <= '0;
        end
        else if (exec_fire)
        begin
            pool_count_reg   <= pool_count_next;
            pool_running_reg <= pool_running_next;
            chan_count_reg   <= chan_count_next;
            chan_enabled_reg <= chan_enabled_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            slot_out_reg  <= res_slot;
            elapsed_reg   <= res_elapsed;
            flag_reg      <= res_flag;
            fire_mask_reg <= res_fire;
        end
    end

    // a stopped pool counter must read zero
    always_comb
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            idle_dirty[i] = !pool_running_reg[i] && (pool_count_reg[i] != '0);
        end
    end

    `ASSERT_NEVER(a_idle_counter_zero, |idle_dirty, "stopped pool counter holds a nonzero count")
    `ASSERT_CLK(a_exec_gives_result, exec_fire |=> out_valid_reg, "executed item left no result")
    `ASSERT_NEVER(a_fire_needs_callback, out_valid_reg && ((fire_mask_reg & ~callback_mask_reg) != '0), "channel fired without callback")
    `ASSERT_CLK(a_one_field_used, out_valid_reg |-> ($countones({|slot_out_reg, |elapsed_reg, flag_reg, |fire_mask_reg}) <= 1), "result carries more than one answer")

endmodule

// ===== tb/tick_timer_pool_tb.sv =====
// Self-checking testbench for tick_timer_pool: directed and random commands,
// checked against a behavioral model of the counters kept in this file.
// Depends on ttp_pkg and the tick_timer_pool RTL.
`timescale 1ns / 100ps

module tick_timer_pool_tb;

    localparam int NUM_SLOTS      = ttp_pkg::POOL_SIZE_DEF;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 230;
    localparam int NUM_PHASES     = 8;
    localparam int HOLD_CYCLES    = 150;

    localparam logic [1:0] CH_FAST = 2'd0;
    localparam logic [1:0] CH_MID  = 2'd1;
    localparam logic [1:0] CH_SLOW = 2'd2;

    // kinds the block does not decode
    localparam logic [3:0] KIND_UNUSED_LO = 4'd13;
    localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

    typedef logic [ttp_pkg::SLOT_OUT_W-1:0] slot_code_t;
    typedef logic [ttp_pkg::FIRE_W-1:0]     fire_bits_t;

    typedef struct {
        logic [ttp_pkg::SLOT_OUT_W-1:0] slot;
        logic [ttp_pkg::COUNT_W-1:0]    count;
        logic                           flag;
        logic [ttp_pkg::FIRE_W-1:0]     fire;
    } timer_reply_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [3:0]                     kind;
    logic [3:0]                     slot_in;
    logic [1:0]                     channel;
    logic [ttp_pkg::COUNT_W-1:0]    limit_ms;
    logic                           out_valid;
    logic                           out_ready;
    logic [ttp_pkg::SLOT_OUT_W-1:0] slot_out;
    logic [ttp_pkg::COUNT_W-1:0]    elapsed;
    logic                           flag;
    logic [ttp_pkg::FIRE_W-1:0]     fire_mask;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ttp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ttp_pkg::CFG_DATA_W-1:0] cfg_data;

    // model state and register copies
    logic [ttp_pkg::COUNT_W-1:0] slot_ticks [NUM_SLOTS];
    logic                        slot_busy  [NUM_SLOTS];
    logic [ttp_pkg::COUNT_W-1:0] chan_ticks [ttp_pkg::NUM_CHAN];
    logic                        chan_on    [ttp_pkg::NUM_CHAN];
    logic [ttp_pkg::FIRE_W-1:0]  cb_shadow;
    logic [ttp_pkg::COUNT_W-1:0] mid_shadow;
    logic [ttp_pkg::COUNT_W-1:0] slow_shadow;

    timer_reply_t awaited_replies [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;

    tick_timer_pool #(.POOL_SIZE(NUM_SLOTS)) i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one command to the model and return the reply it should produce.
    function automatic timer_reply_t advance_timers(input logic [3:0] k, input logic [3:0] s,
                                                    input logic [1:0] c,
                                                    input logic [ttp_pkg::COUNT_W-1:0] lim);
        timer_reply_t                r;
        logic [ttp_pkg::COUNT_W-1:0] period;
        bit                          found;
        r.slot  = '0;
        r.count = '0;
        r.flag  = 1'b0;
        r.fire  = '0;
        found   = 1'b0;
        case (k)
            ttp_pkg::KIND_TICK:
            begin
                // channels count before the pool
                for (int ch = 0; ch < ttp_pkg::NUM_CHAN; ch++)
                begin
                    if (chan_on[ch])
                    begin
                        chan_ticks[ch] += 1'b1;
                        if (cb_shadow[ch])
                        begin
                            if (ch == CH_FAST)
                                r.fire[ch] = 1'b1;
                            else
                            begin
                                period = (ch == CH_MID) ? mid_shadow : slow_shadow;
                                if (chan_ticks[ch] > period)
                                begin
                                    chan_ticks[ch] = '0;
                                    r.fire[ch]     = 1'b1;
                                end
                            end
                        end
                    end
                end
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (slot_busy[i])
                        slot_ticks[i] += 1'b1;
            end
            ttp_pkg::KIND_ALLOC:
            begin
                r.slot = slot_code_t'(NUM_SLOTS);
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && !slot_busy[i])
                    begin
                        found         = 1'b1;
                        slot_busy[i]  = 1'b1;
                        slot_ticks[i] = '0;
                        r.slot        = slot_code_t'(i);
                    end
                end
            end
            // slot_in is 4 bits and the pool holds 16, so every slot is in range
            ttp_pkg::KIND_POOL_STOP:
            begin
                slot_busy[s]  = 1'b0;
                slot_ticks[s] = '0;
            end
            ttp_pkg::KIND_POOL_READ:
                r.count = slot_ticks[s];
            ttp_pkg::KIND_POOL_LESS, ttp_pkg::KIND_POOL_MORE:
            begin
                r.flag = (k == ttp_pkg::KIND_POOL_LESS) ? (slot_ticks[s] < lim)
                                                        : (slot_ticks[s] > lim);
                if (r.flag)
                begin
                    slot_busy[s]  = 1'b0;
                    slot_ticks[s] = '0;
                end
            end
            ttp_pkg::KIND_POOL_STATUS:
                r.flag = slot_busy[s];
            ttp_pkg::KIND_CH_START, ttp_pkg::KIND_CH_STOP, ttp_pkg::KIND_CH_READ,
            ttp_pkg::KIND_CH_LESS, ttp_pkg::KIND_CH_MORE, ttp_pkg::KIND_CH_STATUS:
            begin
                if (c != ttp_pkg::CHAN_INVALID)
                begin
                    case (k)
                        ttp_pkg::KIND_CH_START:
                        begin
                            chan_ticks[c] = '0;
                            chan_on[c]    = 1'b1;
                        end
                        ttp_pkg::KIND_CH_STOP:
                        begin
                            chan_ticks[c] = '0;
                            chan_on[c]    = 1'b0;
                        end
                        ttp_pkg::KIND_CH_READ:   r.count = chan_ticks[c];
                        ttp_pkg::KIND_CH_LESS:   r.flag  = chan_ticks[c] < lim;
                        ttp_pkg::KIND_CH_MORE:   r.flag  = chan_ticks[c] > lim;
                        default:                 r.flag  = chan_on[c];
                    endcase
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    // Drive one command and hold it until the transaction completes.
    task automatic send_cmd(input logic [3:0] k, input logic [3:0] s, input logic [1:0] c,
                            input logic [ttp_pkg::COUNT_W-1:0] lim);
        in_valid <= 1'b1;
        kind     <= k;
        slot_in  <= s;
        channel  <= c;
        limit_ms <= lim;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_replies.push_back(advance_timers(k, s, c, lim));
    endtask

    task automatic idle_gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input ttp_pkg::cfg_reg_t idx,
                             input logic [ttp_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ttp_pkg::CFG_CALLBACK_MASK: cb_shadow   = data[ttp_pkg::FIRE_W-1:0];
            ttp_pkg::CFG_MID_PERIOD:    mid_shadow  = data;
            ttp_pkg::CFG_SLOW_PERIOD:   slow_shadow = data;
            default:                    ;
        endcase
    endtask

    // Only call with nothing in flight.
    task automatic set_config(input logic [ttp_pkg::FIRE_W-1:0] cb,
                              input logic [ttp_pkg::COUNT_W-1:0] mid,
                              input logic [ttp_pkg::COUNT_W-1:0] slow);
        logic [ttp_pkg::CFG_DATA_W-1:0] junk;
        junk = $urandom();
        // upper bits of the mask write carry noise; the block keeps three bits
        write_reg(ttp_pkg::CFG_CALLBACK_MASK, {junk[ttp_pkg::CFG_DATA_W-1:ttp_pkg::FIRE_W], cb});
        write_reg(ttp_pkg::CFG_MID_PERIOD, mid);
        write_reg(ttp_pkg::CFG_SLOW_PERIOD, slow);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_cmd();
        logic [3:0]                  k;
        logic [1:0]                  c;
        logic [ttp_pkg::COUNT_W-1:0] lim;
        int                          pick;
        pick = $urandom_range(99);
        if (pick < 34)      k = ttp_pkg::KIND_TICK;
        else if (pick < 44) k = ttp_pkg::KIND_ALLOC;
        else if (pick < 49) k = ttp_pkg::KIND_POOL_STOP;
        else if (pick < 55) k = ttp_pkg::KIND_POOL_READ;
        else if (pick < 60) k = ttp_pkg::KIND_POOL_LESS;
        else if (pick < 65) k = ttp_pkg::KIND_POOL_MORE;
        else if (pick < 68) k = ttp_pkg::KIND_POOL_STATUS;
        else if (pick < 75) k = ttp_pkg::KIND_CH_START;
        else if (pick < 78) k = ttp_pkg::KIND_CH_STOP;
        else if (pick < 84) k = ttp_pkg::KIND_CH_READ;
        else if (pick < 88) k = ttp_pkg::KIND_CH_LESS;
        else if (pick < 92) k = ttp_pkg::KIND_CH_MORE;
        else if (pick < 96) k = ttp_pkg::KIND_CH_STATUS;
        else                k = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        if ($urandom_range(99) < 6)
            c = ttp_pkg::CHAN_INVALID;
        else
            c = 2'($urandom_range(CH_SLOW));
        // keep most limits near the live counts so both answers show up
        pick = $urandom_range(9);
        if (pick < 6)       lim = $urandom_range(40);
        else if (pick == 6) lim = '0;
        else if (pick == 7) lim = '1;
        else                lim = $urandom();
        if ($urandom_range(99) < tx_idle_pct)
            idle_gap();
        send_cmd(k, 4'($urandom_range(NUM_SLOTS - 1)), c, lim);
    endtask

    task automatic test_pool_directed();
        for (int i = 0; i <= NUM_SLOTS; i++)
            send_cmd(ttp_pkg::KIND_ALLOC, '0, CH_FAST, '0);   // last one finds the pool full
        send_cmd(ttp_pkg::KIND_TICK, '0, CH_FAST, '0);
        send_cmd(ttp_pkg::KIND_POOL_READ, 4'hF, CH_FAST, '0);
        send_cmd(ttp_pkg::KIND_POOL_MORE, 4'h0, CH_FAST, '0);
        send_cmd(ttp_pkg::KIND_POOL_LESS, 4'hF, CH_FAST, '1);
        send_cmd(ttp_pkg::KIND_POOL_STOP, 4'h3, CH_FAST, '0);
        send_cmd(ttp_pkg::KIND_POOL_STATUS, 4'h3, CH_FAST, '0);
    endtask

    task automatic test_channel_directed();
        wait_drain();
        set_config('1, '0, 32'd1);
        send_cmd(ttp_pkg::KIND_CH_START, '0, CH_FAST, '0);
        send_cmd(ttp_pkg::KIND_CH_START, '0, CH_SLOW, '0);
        send_cmd(ttp_pkg::KIND_TICK, '0, CH_FAST, '0);
        send_cmd(ttp_pkg::KIND_TICK, '0, CH_FAST, '0);
        send_cmd(ttp_pkg::KIND_CH_READ, '0, CH_SLOW, '0);
        send_cmd(ttp_pkg::KIND_CH_LESS, '0, CH_MID, '0);
        send_cmd(ttp_pkg::KIND_CH_MORE, '0, CH_FAST, '0);
        send_cmd(ttp_pkg::KIND_CH_STATUS, '0, CH_SLOW, '0);
        send_cmd(ttp_pkg::KIND_CH_STOP, '0, CH_FAST, '0);
        send_cmd(ttp_pkg::KIND_CH_START, '0, ttp_pkg::CHAN_INVALID, '0);
        send_cmd(KIND_UNUSED_HI, '0, CH_FAST, '0);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drain();
            case (ph)
                0:       set_config('1, 32'd20, 32'd100);
                1:       set_config('1, '0, 32'd1);
                2:       set_config('0, '1, '1);
                3:       set_config(3'b110, 32'd3, '0);
                4:       set_config('1, '1, '0);
                5:       set_config(3'b011, 32'd5, 32'd9);
                default: set_config(fire_bits_t'($urandom_range(7)), $urandom_range(25),
                                    $urandom_range(60));
            endcase
            case (ph % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 53; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
            endcase
            repeat (PHASE_ITEMS) send_random_cmd();
        end
    endtask

    // Block the result side while commands keep coming, then let it drain.
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = HOLD_CYCLES;
        repeat (40) send_random_cmd();
        wait_drain();
        repeat (20) send_random_cmd();
    endtask

    // result side: random stalls plus a long hold while rx_hold_left is set
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : reply_check
        timer_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_replies.size() == 0)
                note_mismatch($sformatf("unexpected result slot=%0d elapsed=%0d flag=%0b fire=%b",
                                        slot_out, elapsed, flag, fire_mask));
            else
            begin
                want = awaited_replies.pop_front();
                if (slot_out !== want.slot || elapsed !== want.count || flag !== want.flag ||
                    fire_mask !== want.fire)
                    note_mismatch($sformatf({"exp slot=%0d elapsed=%0d flag=%0b fire=%b, ",
                                             "got slot=%0d elapsed=%0d flag=%0b fire=%b"},
                                            want.slot, want.count, want.flag, want.fire,
                                            slot_out, elapsed, flag, fire_mask));
            end
        end
    end

    // end the run if no transaction completes for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** tick_timer_pool: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = ttp_pkg::KIND_TICK;
        slot_in   = '0;
        channel   = CH_FAST;
        limit_ms  = '0;
        cfg_valid = 1'b0;
        cfg_index = ttp_pkg::CFG_CALLBACK_MASK;
        cfg_data  = '0;
        cb_shadow   = ttp_pkg::CALLBACK_RST;
        mid_shadow  = ttp_pkg::MID_PERIOD_RST;
        slow_shadow = ttp_pkg::SLOW_PERIOD_RST;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_ticks[i] = '0;
            slot_busy[i]  = 1'b0;
        end
        for (int i = 0; i < ttp_pkg::NUM_CHAN; i++)
        begin
            chan_ticks[i] = '0;
            chan_on[i]    = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_pool_directed();
        test_channel_directed();
        test_random_phases();
        test_backpressure();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_replies.size() == 0)
            $display("** tick_timer_pool: PASSED **");
        else
            $display("** tick_timer_pool: FAILED **");
        $finish;
    end

endmodule
